// File: hw/rtl/bhfl_pkg.sv
// Package: shared types, request codes and alignment constants for the heap allocator.
package bhfl_pkg;

    // Request codes carried on i_req_type
    typedef enum logic [2:0] {
        REQ_ALLOC   = 3'd0,
        REQ_RELEASE = 3'd1,
        REQ_BROKEN  = 3'd2,
        REQ_CLEAR   = 3'd3,
        REQ_RESTART = 3'd4
    } t_req;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ASCAN,
        S_RSCAN
    } t_state;

    localparam logic [31:0] WORD_ALIGN   = 32'd4;
    localparam logic [31:0] PAGE_ALIGN   = 32'h0000_1000;
    localparam logic [31:0] RELEASE_SIZE = 32'd4;
    localparam int          ADDR_W       = 32;
    localparam int          SIZE_W       = 32;
    localparam int          ENTRY_W      = ADDR_W + SIZE_W;

    // Round v up to a power-of-two alignment a, wrapping at 32 bits
    function automatic logic [31:0] round_up(input logic [31:0] v, input logic [31:0] a);
        return (v + a - 32'd1) & ~(a - 32'd1);
    endfunction

endpackage

// File: hw/rtl/bhfl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bhfl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/bump_heap_with_free_list_unit.sv
// Heap allocator: bump pointer backed by a first-fit free table held in a RAM.
// Control requests, zero-size allocates and rejected releases finish without a scan.
// Allocates skip the scan with an empty table, else read the free-table RAM one slot
// per cycle until a fit or the end. Releases walk the valid flops to the lowest empty slot.
// One transaction at a time; a new start is taken in the cycle the result strobes.
// Reset (synchronous, active low) empties the table through its valid flops at once.
module bump_heap_with_free_list_unit #(
    parameter int FREE_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_block_address,
    output logic        o_done,
    output logic [31:0] o_result_address,
    output logic [31:0] o_alloc_count,
    output logic [31:0] o_release_count,
    output logic [31:0] o_reuse_count,
    output logic [5:0]  o_free_entries,
    output logic [31:0] o_failed_release_count,
    output logic [31:0] o_next_address,
    output logic        o_healthy
);

    localparam int IDX_W = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int CNT_W = $clog2(FREE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(FREE_SLOTS);

    bhfl_pkg::t_state r_state, n_state;

    logic [31:0]           r_heap_start;
    logic [31:0]           r_bump, n_bump;
    logic [31:0]           r_allocs, n_allocs;
    logic [31:0]           r_releases, n_releases;
    logic [31:0]           r_reuses, n_reuses;
    logic [31:0]           r_fails, n_fails;
    logic [FREE_SLOTS-1:0] r_occ, n_occ;
    logic [CNT_W-1:0]      r_occ_cnt, n_occ_cnt;
    logic [CNT_W-1:0]      r_idx, n_idx;
    logic                  r_rd_pend, n_rd_pend;
    logic                  r_rd_occ, n_rd_occ;
    logic [IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic [31:0]           r_need, n_need;
    logic [31:0]           r_rel_addr, n_rel_addr;
    logic [31:0]           r_result, n_result;
    logic                  r_done, n_done;

    logic                        accept;
    logic [31:0]                 need_in;
    logic                        hit;
    logic                        ram_we;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_waddr;
    logic [IDX_W-1:0]            ram_raddr;
    logic [bhfl_pkg::ENTRY_W-1:0] ram_wdata;
    logic [bhfl_pkg::ENTRY_W-1:0] ram_rdata;
    logic [31:0]                 rd_addr;
    logic [31:0]                 rd_size;

    assign accept  = start && (r_state == bhfl_pkg::S_IDLE);
    assign need_in = bhfl_pkg::round_up(i_request_size, bhfl_pkg::WORD_ALIGN);
    assign rd_addr = ram_rdata[bhfl_pkg::ENTRY_W-1:bhfl_pkg::SIZE_W];
    assign rd_size = ram_rdata[bhfl_pkg::SIZE_W-1:0];
    assign hit     = r_rd_pend && r_rd_occ && (rd_size >= r_need);

    // Free table: {address, size} per slot
    bhfl_ram #(
        .WIDTH(bhfl_pkg::ENTRY_W),
        .DEPTH(FREE_SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bhfl_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req_type == bhfl_pkg::REQ_ALLOC && i_request_size != 32'd0) begin
                        n_state = bhfl_pkg::S_ASCAN;
                    end else if (i_req_type == bhfl_pkg::REQ_RELEASE &&
                                 i_block_address != 32'd0 && r_occ_cnt != SLOTS) begin
                        n_state = bhfl_pkg::S_RSCAN;
                    end
                end
            end
            bhfl_pkg::S_ASCAN: begin
                if (hit || (r_idx == SLOTS && !r_rd_pend)) begin
                    n_state = bhfl_pkg::S_IDLE;
                end
            end
            bhfl_pkg::S_RSCAN: begin
                if (!r_occ[r_idx[IDX_W-1:0]]) begin
                    n_state = bhfl_pkg::S_IDLE;
                end
            end
            default: n_state = bhfl_pkg::S_IDLE;
        endcase
    end

    // Datapath, RAM control and result
    always_comb begin
        n_bump     = r_bump;
        n_allocs   = r_allocs;
        n_releases = r_releases;
        n_reuses   = r_reuses;
        n_fails    = r_fails;
        n_occ      = r_occ;
        n_occ_cnt  = r_occ_cnt;
        n_idx      = r_idx;
        n_rd_pend  = 1'b0;
        n_rd_occ   = 1'b0;
        n_rd_idx   = r_rd_idx;
        n_need     = r_need;
        n_rel_addr = r_rel_addr;
        n_result   = r_result;
        n_done     = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = r_idx[IDX_W-1:0];
        ram_raddr  = r_idx[IDX_W-1:0];
        ram_wdata  = {r_rel_addr, bhfl_pkg::RELEASE_SIZE};
        unique case (r_state)
            bhfl_pkg::S_IDLE: begin
                if (accept) begin
                    n_result   = 32'd0;
                    n_need     = need_in;
                    n_rel_addr = i_block_address;
                    // empty table goes straight to the bump path
                    n_idx      = (r_occ_cnt == '0) ? SLOTS : '0;
                    case (i_req_type)
                        bhfl_pkg::REQ_ALLOC: begin
                            n_done = (i_request_size == 32'd0);
                        end
                        bhfl_pkg::REQ_RELEASE: begin
                            if (i_block_address == 32'd0 || r_occ_cnt == SLOTS) begin
                                n_fails = r_fails + 32'd1;
                                n_done  = 1'b1;
                            end
                            n_idx = '0;
                        end
                        bhfl_pkg::REQ_BROKEN: begin
                            n_fails = r_fails + 32'd1;
                            n_done  = 1'b1;
                        end
                        bhfl_pkg::REQ_CLEAR: begin
                            n_fails = 32'd0;
                            n_done  = 1'b1;
                        end
                        bhfl_pkg::REQ_RESTART: begin
                            n_bump     = bhfl_pkg::round_up(r_heap_start,
                                                            bhfl_pkg::PAGE_ALIGN);
                            n_occ      = '0;
                            n_occ_cnt  = '0;
                            n_allocs   = 32'd0;
                            n_releases = 32'd0;
                            n_reuses   = 32'd0;
                            n_fails    = 32'd0;
                            n_done     = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            bhfl_pkg::S_ASCAN: begin
                if (hit) begin
                    // first fit: take the slot just read
                    n_result          = rd_addr;
                    n_occ[r_rd_idx]   = 1'b0;
                    n_occ_cnt         = r_occ_cnt - CNT_W'(1);
                    n_allocs          = r_allocs + 32'd1;
                    n_reuses          = r_reuses + 32'd1;
                    n_done            = 1'b1;
                end else if (r_idx == SLOTS && !r_rd_pend) begin
                    // no fit: bump allocate
                    n_result = r_bump;
                    n_bump   = bhfl_pkg::round_up(r_bump + r_need, bhfl_pkg::WORD_ALIGN);
                    n_allocs = r_allocs + 32'd1;
                    n_done   = 1'b1;
                end else if (r_idx != SLOTS) begin
                    // issue read of the next slot
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_rd_occ  = r_occ[r_idx[IDX_W-1:0]];
                    n_rd_idx  = r_idx[IDX_W-1:0];
                    n_idx     = r_idx + CNT_W'(1);
                end
            end
            bhfl_pkg::S_RSCAN: begin
                if (!r_occ[r_idx[IDX_W-1:0]]) begin
                    // lowest empty slot found: record the release
                    ram_we                    = 1'b1;
                    n_occ[r_idx[IDX_W-1:0]]   = 1'b1;
                    n_occ_cnt                 = r_occ_cnt + CNT_W'(1);
                    n_releases                = r_releases + 32'd1;
                    n_done                    = 1'b1;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bhfl_pkg::S_IDLE;
            r_heap_start <= 32'd0;
            r_bump       <= 32'd0;
            r_allocs     <= 32'd0;
            r_releases   <= 32'd0;
            r_reuses     <= 32'd0;
            r_fails      <= 32'd0;
            r_occ        <= '0;
            r_occ_cnt    <= '0;
            r_idx        <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_occ     <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (i_cfg_we) begin
                r_heap_start <= i_cfg_wdata;
            end
            r_bump     <= n_bump;
            r_allocs   <= n_allocs;
            r_releases <= n_releases;
            r_reuses   <= n_reuses;
            r_fails    <= n_fails;
            r_occ      <= n_occ;
            r_occ_cnt  <= n_occ_cnt;
            r_idx      <= n_idx;
            r_rd_pend  <= n_rd_pend;
            r_rd_occ   <= n_rd_occ;
            r_done     <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_need     <= n_need;
        r_rel_addr <= n_rel_addr;
        r_result   <= n_result;
    end

    assign busy                   = (r_state != bhfl_pkg::S_IDLE);
    assign o_done                 = r_done;
    assign o_result_address       = r_result;
    assign o_alloc_count          = r_allocs;
    assign o_release_count        = r_releases;
    assign o_reuse_count          = r_reuses;
    assign o_free_entries         = 6'(r_occ_cnt);
    assign o_failed_release_count = r_fails;
    assign o_next_address         = r_bump;
    assign o_healthy              = (r_bump != 32'd0) && (r_fails == 32'd0);

`ifndef SYNTHESIS
    // occupancy counter tracks the valid flops
    a_occ_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ_cnt == CNT_W'($countones(r_occ)))
        else $error("occupancy count out of step with slot valid bits");

    // a release never overwrites an occupied slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_occ[ram_waddr])
        else $error("free-table write to an occupied slot");

    // release scan only runs with room in the table
    a_rscan_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bhfl_pkg::S_RSCAN) |-> (r_occ_cnt < SLOTS))
        else $error("release scan started on a full table");

    // a result follows either an accepted request or a running scan
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> ($past(accept) || $past(busy)))
        else $error("result strobe without a transaction");

    // read and write never hit the RAM in the same cycle
    a_ram_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("free-table read and write overlap");
`endif

endmodule

// File: bench/heap_alloc_checker.sv
// Checker for the heap allocator: predicts every request's status and compares the results.
module heap_alloc_checker #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_request_size,
    input  logic [31:0] i_block_address,
    input  logic        o_done,
    input  logic [31:0] o_result_address,
    input  logic [31:0] o_alloc_count,
    input  logic [31:0] o_release_count,
    input  logic [31:0] o_reuse_count,
    input  logic [5:0]  o_free_entries,
    input  logic [31:0] o_failed_release_count,
    input  logic [31:0] o_next_address,
    input  logic        o_healthy,
    output int          mismatch_count,
    output int          awaiting_count
);

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] allocs;
        logic [31:0] releases;
        logic [31:0] reuses;
        logic [5:0]  free;
        logic [31:0] failures;
        logic [31:0] bump;
        logic        healthy;
    } t_heap_status;

    // Shadow copy of the allocator
    logic [31:0] heap_base;
    logic [31:0] free_addr [SLOTS];
    logic [31:0] free_len [SLOTS];
    logic        free_used [SLOTS];
    logic [31:0] bump_ptr;
    logic [31:0] alloc_total;
    logic [31:0] release_total;
    logic [31:0] reuse_total;
    logic [31:0] failure_total;

    t_heap_status pending_status [$];

    // Round up to a power-of-two boundary, wrapping at 32 bits
    function automatic logic [31:0] ceil_to(input logic [31:0] v, input logic [31:0] a);
        logic [31:0] rem;
        rem = v & (a - 32'd1);
        return (rem == 32'd0) ? v : v + (a - rem);
    endfunction

    // Empty the free table and zero the counters
    function automatic void wipe_heap();
        for (int i = 0; i < SLOTS; i++) begin
            free_addr[i] = '0;
            free_len[i]  = '0;
            free_used[i] = 1'b0;
        end
        alloc_total   = '0;
        release_total = '0;
        reuse_total   = '0;
        failure_total = '0;
    endfunction

    // Apply one request to the shadow heap and return the status it reports
    function automatic t_heap_status apply_request(input logic [2:0] req,
                                                   input logic [31:0] size,
                                                   input logic [31:0] addr);
        t_heap_status st;
        logic [31:0]  need;
        logic         found;
        int           occupied;
        st = '0;
        found = 1'b0;
        occupied = 0;
        case (req)
            bhfl_pkg::REQ_ALLOC: begin
                if (size != 32'd0) begin
                    need = ceil_to(size, bhfl_pkg::WORD_ALIGN);
                    // first fit in slot order
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && free_used[i] && free_len[i] >= need) begin
                            found = 1'b1;
                            st.addr = free_addr[i];
                            free_addr[i] = '0;
                            free_len[i]  = '0;
                            free_used[i] = 1'b0;
                            reuse_total++;
                        end
                    end
                    if (!found) begin
                        st.addr  = bump_ptr;
                        bump_ptr = ceil_to(bump_ptr + need, bhfl_pkg::WORD_ALIGN);
                    end
                    alloc_total++;
                end
            end
            bhfl_pkg::REQ_RELEASE: begin
                if (addr == 32'd0) begin
                    failure_total++;
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!found && !free_used[i]) begin
                            found = 1'b1;
                            free_addr[i] = addr;
                            free_len[i]  = bhfl_pkg::RELEASE_SIZE;
                            free_used[i] = 1'b1;
                            release_total++;
                        end
                    end
                    // table full
                    if (!found) failure_total++;
                end
            end
            bhfl_pkg::REQ_BROKEN:  failure_total++;
            bhfl_pkg::REQ_CLEAR:   failure_total = '0;
            bhfl_pkg::REQ_RESTART: begin
                bump_ptr = ceil_to(heap_base, bhfl_pkg::PAGE_ALIGN);
                wipe_heap();
            end
            default: ;
        endcase
        for (int i = 0; i < SLOTS; i++)
            if (free_used[i]) occupied++;
        st.allocs   = alloc_total;
        st.releases = release_total;
        st.reuses   = reuse_total;
        st.free     = 6'(occupied);
        st.failures = failure_total;
        st.bump     = bump_ptr;
        st.healthy  = (bump_ptr != 32'd0) && (failure_total == 32'd0);
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("heap check: %s got %h expected %h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Predict on each accepted request, compare on each strobed result
    always @(posedge i_clk) begin : watch
        t_heap_status got;
        t_heap_status want;
        if (!i_rst_n) begin
            heap_base = '0;
            bump_ptr  = '0;
            wipe_heap();
            pending_status.delete();
        end else begin
            if (i_cfg_we) heap_base = i_cfg_wdata;
            if (o_done) begin
                got.addr     = o_result_address;
                got.allocs   = o_alloc_count;
                got.releases = o_release_count;
                got.reuses   = o_reuse_count;
                got.free     = o_free_entries;
                got.failures = o_failed_release_count;
                got.bump     = o_next_address;
                got.healthy  = o_healthy;
                if (pending_status.size() == 0) begin
                    report_mismatch("result with no transaction pending", got.addr, '0);
                end else begin
                    want = pending_status.pop_front();
                    if (got.addr !== want.addr)
                        report_mismatch("result_address", got.addr, want.addr);
                    if (got.allocs !== want.allocs)
                        report_mismatch("alloc_count", got.allocs, want.allocs);
                    if (got.releases !== want.releases)
                        report_mismatch("release_count", got.releases, want.releases);
                    if (got.reuses !== want.reuses)
                        report_mismatch("reuse_count", got.reuses, want.reuses);
                    if (got.free !== want.free)
                        report_mismatch("free_entries", 32'(got.free), 32'(want.free));
                    if (got.failures !== want.failures)
                        report_mismatch("failed_release_count", got.failures, want.failures);
                    if (got.bump !== want.bump)
                        report_mismatch("next_address", got.bump, want.bump);
                    if (got.healthy !== want.healthy)
                        report_mismatch("healthy", 32'(got.healthy), 32'(want.healthy));
                end
            end
            if (start && !busy)
                pending_status.push_back(apply_request(i_req_type, i_request_size,
                                                       i_block_address));
        end
        awaiting_count <= pending_status.size();
    end

endmodule

// File: bench/testbench.sv
// Testbench top: drives heap allocator requests and heap_start writes, gives the verdict.
module testbench;

    localparam int         IDLE_LIMIT   = 2000;
    localparam int         PHASE_ITEMS  = 205;
    localparam int         PHASES       = 7;
    localparam int         POOL_DEPTH   = 48;
    localparam logic [2:0] REQ_SPARE_LO = 3'd5;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [31:0] i_cfg_wdata     = '0;
    logic        start           = 1'b0;
    logic [2:0]  i_req_type      = '0;
    logic [31:0] i_request_size  = '0;
    logic [31:0] i_block_address = '0;

    logic        busy;
    logic        o_done;
    logic [31:0] o_result_address;
    logic [31:0] o_alloc_count;
    logic [31:0] o_release_count;
    logic [31:0] o_reuse_count;
    logic [5:0]  o_free_entries;
    logic [31:0] o_failed_release_count;
    logic [31:0] o_next_address;
    logic        o_healthy;

    int          mismatch_count;
    int          awaiting_count;
    int          idle_cycles = 0;
    logic        steady_mode = 1'b0;
    logic [31:0] handed_out [$];

    always #1 i_clk = ~i_clk;

    bump_heap_with_free_list_unit dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .start                  (start),
        .busy                   (busy),
        .i_req_type             (i_req_type),
        .i_request_size         (i_request_size),
        .i_block_address        (i_block_address),
        .o_done                 (o_done),
        .o_result_address       (o_result_address),
        .o_alloc_count          (o_alloc_count),
        .o_release_count        (o_release_count),
        .o_reuse_count          (o_reuse_count),
        .o_free_entries         (o_free_entries),
        .o_failed_release_count (o_failed_release_count),
        .o_next_address         (o_next_address),
        .o_healthy              (o_healthy)
    );

    heap_alloc_checker heap_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .start                  (start),
        .busy                   (busy),
        .i_req_type             (i_req_type),
        .i_request_size         (i_request_size),
        .i_block_address        (i_block_address),
        .o_done                 (o_done),
        .o_result_address       (o_result_address),
        .o_alloc_count          (o_alloc_count),
        .o_release_count        (o_release_count),
        .o_reuse_count          (o_reuse_count),
        .o_free_entries         (o_free_entries),
        .o_failed_release_count (o_failed_release_count),
        .o_next_address         (o_next_address),
        .o_healthy              (o_healthy),
        .mismatch_count         (mismatch_count),
        .awaiting_count         (awaiting_count)
    );

    // Remember recent allocations so releases hand back real blocks
    always @(posedge i_clk) begin
        if (o_done && o_result_address != 32'd0) begin
            handed_out.push_back(o_result_address);
            if (handed_out.size() > POOL_DEPTH) void'(handed_out.pop_front());
        end
    end

    // Watchdog: cycles with neither a request nor a result accepted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One request transaction, then a random gap unless in a steady stretch
    task automatic issue(input logic [2:0] req, input logic [31:0] size,
                         input logic [31:0] addr);
        int gap;
        int roll;
        start           <= 1'b1;
        i_req_type      <= req;
        i_request_size  <= size;
        i_block_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        gap = 0;
        if (!steady_mode) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90) gap = $urandom_range(10, 60);
            else if (roll >= 55) gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaiting_count != 0) @(posedge i_clk);
    endtask

    task automatic set_heap_start(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [31:0] phase_base [PHASES];
        int          release_bias [PHASES];
        int          roll;
        logic [2:0]  req;
        logic [31:0] size;
        logic [31:0] addr;
        phase_base   = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_F000, 32'h0000_0001,
                         $urandom, $urandom, 32'h7FFF_F800};
        release_bias = '{90, 50, 20, 60, 35, 70, 45};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_heap_start(32'h0001_2345);

        // Directed: allocate before restart, edge sizes, reuse, failures, spare codes
        issue(bhfl_pkg::REQ_ALLOC,    32'd8,          32'd0);
        issue(bhfl_pkg::REQ_RESTART,  32'd0,          32'd0);
        issue(bhfl_pkg::REQ_ALLOC,    32'd0,          32'hFFFF_FFFF);
        issue(bhfl_pkg::REQ_ALLOC,    32'd1,          32'd0);
        issue(bhfl_pkg::REQ_ALLOC,    32'd5,          32'd0);
        issue(bhfl_pkg::REQ_RELEASE,  32'd0,          32'd0);
        issue(bhfl_pkg::REQ_CLEAR,    32'd0,          32'd0);
        issue(bhfl_pkg::REQ_RELEASE,  32'd0,          32'h0001_3000);
        issue(bhfl_pkg::REQ_RELEASE,  32'd0,          32'h0001_3000);
        issue(bhfl_pkg::REQ_ALLOC,    32'd4,          32'd0);
        issue(bhfl_pkg::REQ_ALLOC,    32'hFFFF_FFFF,  32'd0);
        issue(bhfl_pkg::REQ_ALLOC,    32'hFFFF_FFFD,  32'd0);
        issue(bhfl_pkg::REQ_ALLOC,    32'hFFFF_FFFC,  32'd0);
        issue(bhfl_pkg::REQ_BROKEN,   32'd0,          32'd0);
        issue(bhfl_pkg::REQ_RELEASE,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        issue(REQ_SPARE_LO,           32'hFFFF_FFFF,  32'hFFFF_FFFF);
        issue(REQ_SPARE_LO + 3'd1,    32'd0,          32'd0);
        issue(REQ_SPARE_HI,           32'h5555_AAAA,  32'hAAAA_5555);
        issue(bhfl_pkg::REQ_CLEAR,    32'd0,          32'd0);
        issue(bhfl_pkg::REQ_RESTART,  32'd0,          32'd0);

        // Random phases, each from a fresh heap_start and a restart
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            set_heap_start(phase_base[p]);
            issue(bhfl_pkg::REQ_RESTART, $urandom, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 49) == 0) steady_mode = !steady_mode;

                roll = $urandom_range(0, 99);
                if (roll < release_bias[p]) begin
                    req = bhfl_pkg::REQ_RELEASE;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 82)      req = bhfl_pkg::REQ_ALLOC;
                    else if (roll < 87) req = bhfl_pkg::REQ_BROKEN;
                    else if (roll < 92) req = bhfl_pkg::REQ_CLEAR;
                    else if (roll < 95) req = bhfl_pkg::REQ_RESTART;
                    else                req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
                end

                // sizes: 1 to 4 most often, small enough to reuse a freed block
                roll = $urandom_range(0, 99);
                if (roll < 8)       size = 32'd0;
                else if (roll < 50) size = $urandom_range(1, 4);
                else if (roll < 80) size = $urandom_range(5, 64);
                else if (roll < 90) size = $urandom_range(65, 4096);
                else if (roll < 96) size = $urandom;
                else                size = $urandom_range(32'hFFFF_FFF8, 32'hFFFF_FFFF);

                // addresses: mostly blocks handed out earlier
                roll = $urandom_range(0, 99);
                if (roll < 70 && handed_out.size() > 0)
                    addr = handed_out[$urandom_range(0, handed_out.size() - 1)];
                else if (roll < 80)
                    addr = 32'd0;
                else
                    addr = $urandom;

                issue(req, size, addr);
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && awaiting_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: bump_heap_with_free_list_unit.f
hw/rtl/bhfl_pkg.sv
hw/rtl/bhfl_ram.sv
hw/rtl/bump_heap_with_free_list_unit.sv
bench/heap_alloc_checker.sv
bench/testbench.sv
